/* rtl/assert_macros.svh */
// assertion helpers for modules clocked by clk with reset arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_AT(label, !(cond), msg)

`endif

/* rtl/tosc_pkg.sv */
package tosc_pkg;

	localparam int PHASE_BITS    = 32;
	localparam int SINE_DEPTH    = 256;
	localparam int SINE_IDX_BITS = $clog2(SINE_DEPTH);
	localparam int SINE_VAL_BITS = 15;
	localparam int SAMPLE_BITS   = 16;
	localparam int LEVEL_BITS    = 17;
	localparam int STEP_BITS     = 17;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SINE_STEP    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SAW_STEP     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_STEP   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_WIDTH  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK_STEP  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_STEP = 3'd5;

	localparam logic [PHASE_BITS-1:0] RST_SINE_STEP   = 32'd21424120;
	localparam logic [PHASE_BITS-1:0] RST_SAW_STEP    = 32'd64336724;
	localparam logic [PHASE_BITS-1:0] RST_PULSE_STEP  = 32'd26753326;
	localparam logic [PHASE_BITS-1:0] RST_PULSE_WIDTH = 32'd1073741824;
	localparam logic [STEP_BITS-1:0]  RST_ATTACK_STEP  = 17'd149;
	localparam logic [STEP_BITS-1:0]  RST_RELEASE_STEP = 17'd2;

	localparam logic [LEVEL_BITS-1:0] ENV_FULL = 17'd65536;

	// shared multiplier: signed 32 x signed 18
	localparam int MUL_A_BITS = 32;
	localparam int MUL_B_BITS = 18;
	localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

	localparam logic signed [MUL_B_BITS-1:0] GAIN_SINE  = 18'sd13107;
	localparam logic signed [MUL_B_BITS-1:0] GAIN_SAW   = 18'sd3277;
	localparam logic signed [MUL_A_BITS-1:0] PULSE_TERM = 32'sd85884928;
	localparam logic signed [MUL_B_BITS-1:0] SAMPLE_MAX = 18'sd32767;
	localparam int LEVEL_SHIFT = 16;
	localparam int OUT_SHIFT   = 31;

	typedef enum logic [1:0] {
		ST_ATTACK  = 2'd0,
		ST_RELEASE = 2'd1,
		ST_DONE    = 2'd2
	} env_stage_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MSINE,
		B_MSAW,
		B_MIX,
		B_MLVL,
		B_MAG,
		B_MMAX,
		B_OUT
	} back_state_t;

	// one sample's worth of voice values, handed from front to back
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sine;
		logic signed [SAMPLE_BITS-1:0] saw;
		logic                          pulse;
		logic [LEVEL_BITS-1:0]         level;
		logic                          done;
	} job_t;

	typedef logic [SINE_VAL_BITS-1:0] sine_rom_t [SINE_DEPTH];

	// quarter-wave table from a truncated taylor series in q30
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] a;
		logic [63:0] s;
		logic [63:0] e;
		int q;
		for (q = 0; q < SINE_DEPTH; q++) begin
			x  = (64'd1686629713 * 64'(2 * q + 1)) / 64'(2 * SINE_DEPTH);
			x2 = (x * x) >> 30;
			a  = 64'd1073741824 - x2 / 64'd72;
			a  = 64'd1073741824 - ((x2 * a) >> 30) / 64'd42;
			a  = 64'd1073741824 - ((x2 * a) >> 30) / 64'd20;
			a  = 64'd1073741824 - ((x2 * a) >> 30) / 64'd6;
			s  = (x * a) >> 30;
			e  = (s * 64'd32767 + 64'd536870912) >> 30;
			if (e > 64'd32767) begin
				e = 64'd32767;
			end
			rom[q] = e[SINE_VAL_BITS-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* rtl/tosc_front.sv */
`include "assert_macros.svh"

module tosc_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [tosc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [tosc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                 accept,
	input  logic                                 restart,
	output tosc_pkg::job_t                       job
);

	logic [tosc_pkg::PHASE_BITS-1:0] sine_step_q;
	logic [tosc_pkg::PHASE_BITS-1:0] saw_step_q;
	logic [tosc_pkg::PHASE_BITS-1:0] pulse_step_q;
	logic [tosc_pkg::PHASE_BITS-1:0] pulse_width_q;
	logic [tosc_pkg::STEP_BITS-1:0]  attack_step_q;
	logic [tosc_pkg::STEP_BITS-1:0]  release_step_q;

	logic [tosc_pkg::PHASE_BITS-1:0] sine_ph_q;
	logic [tosc_pkg::PHASE_BITS-1:0] saw_ph_q;
	logic [tosc_pkg::PHASE_BITS-1:0] pulse_ph_q;
	logic [tosc_pkg::LEVEL_BITS-1:0] level_q;
	tosc_pkg::env_stage_t            stage_q;

	logic [tosc_pkg::PHASE_BITS-1:0] sine_ph;
	logic [tosc_pkg::PHASE_BITS-1:0] saw_ph;
	logic [tosc_pkg::PHASE_BITS-1:0] pulse_ph;
	logic [tosc_pkg::LEVEL_BITS-1:0] level;
	tosc_pkg::env_stage_t            stage;
	logic                            done;

	logic [tosc_pkg::LEVEL_BITS-1:0] att;
	logic [tosc_pkg::LEVEL_BITS-1:0] rel;
	logic [tosc_pkg::LEVEL_BITS:0]   rise;
	logic [tosc_pkg::LEVEL_BITS-1:0] level_d;
	tosc_pkg::env_stage_t            stage_d;

	logic [1:0]                         quad;
	logic [tosc_pkg::SINE_IDX_BITS-1:0] sidx;
	logic [tosc_pkg::SINE_VAL_BITS-1:0] sval;
	logic signed [tosc_pkg::SAMPLE_BITS-1:0] sine_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sine_step_q    <= tosc_pkg::RST_SINE_STEP;
			saw_step_q     <= tosc_pkg::RST_SAW_STEP;
			pulse_step_q   <= tosc_pkg::RST_PULSE_STEP;
			pulse_width_q  <= tosc_pkg::RST_PULSE_WIDTH;
			attack_step_q  <= tosc_pkg::RST_ATTACK_STEP;
			release_step_q <= tosc_pkg::RST_RELEASE_STEP;
		end else if (cfg_wen) begin
			case (cfg_index)
				tosc_pkg::REG_SINE_STEP:    sine_step_q    <= cfg_data;
				tosc_pkg::REG_SAW_STEP:     saw_step_q     <= cfg_data;
				tosc_pkg::REG_PULSE_STEP:   pulse_step_q   <= cfg_data;
				tosc_pkg::REG_PULSE_WIDTH:  pulse_width_q  <= cfg_data;
				tosc_pkg::REG_ATTACK_STEP:  attack_step_q  <= cfg_data[tosc_pkg::STEP_BITS-1:0];
				tosc_pkg::REG_RELEASE_STEP: release_step_q <= cfg_data[tosc_pkg::STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// restart clears the voice before this sample is made
	always_comb begin
		sine_ph  = restart ? '0 : sine_ph_q;
		saw_ph   = restart ? '0 : saw_ph_q;
		pulse_ph = restart ? '0 : pulse_ph_q;
		level    = restart ? '0 : level_q;
		stage    = restart ? tosc_pkg::ST_ATTACK : stage_q;
		done     = !(stage == tosc_pkg::ST_ATTACK || stage == tosc_pkg::ST_RELEASE);
	end

	always_comb begin
		att  = (attack_step_q > tosc_pkg::ENV_FULL) ? tosc_pkg::ENV_FULL : attack_step_q;
		rel  = (release_step_q > tosc_pkg::ENV_FULL) ? tosc_pkg::ENV_FULL : release_step_q;
		rise = {1'b0, level} + {1'b0, att};
		case (stage)
			tosc_pkg::ST_ATTACK: begin
				if (rise >= {1'b0, tosc_pkg::ENV_FULL}) begin
					level_d = tosc_pkg::ENV_FULL;
					stage_d = tosc_pkg::ST_RELEASE;
				end else begin
					level_d = rise[tosc_pkg::LEVEL_BITS-1:0];
					stage_d = tosc_pkg::ST_ATTACK;
				end
			end
			tosc_pkg::ST_RELEASE: begin
				// zero release step means silence right after the peak
				if (rel == '0 || level <= rel) begin
					level_d = '0;
				end else begin
					level_d = level - rel;
				end
				stage_d = (level_d == '0) ? tosc_pkg::ST_DONE : tosc_pkg::ST_RELEASE;
			end
			default: begin
				level_d = '0;
				stage_d = tosc_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sine_ph_q  <= '0;
			saw_ph_q   <= '0;
			pulse_ph_q <= '0;
			level_q    <= '0;
			stage_q    <= tosc_pkg::ST_ATTACK;
		end else if (accept) begin
			sine_ph_q  <= sine_ph + sine_step_q;
			saw_ph_q   <= saw_ph + saw_step_q;
			pulse_ph_q <= pulse_ph + pulse_step_q;
			level_q    <= level_d;
			stage_q    <= stage_d;
		end
	end

	// quadrant mirror and sign around the quarter-wave table
	always_comb begin
		quad = sine_ph[tosc_pkg::PHASE_BITS-1 -: 2];
		sidx = sine_ph[tosc_pkg::PHASE_BITS-3 -: tosc_pkg::SINE_IDX_BITS];
		if (quad[0]) begin
			sidx = ~sidx;
		end
		sval     = tosc_pkg::SINE_ROM[sidx];
		sine_pos = $signed({1'b0, sval});
		job.sine = quad[1] ? -sine_pos : sine_pos;
		job.saw  = $signed({~saw_ph[tosc_pkg::PHASE_BITS-1],
			saw_ph[tosc_pkg::PHASE_BITS-2 -: tosc_pkg::SAMPLE_BITS-1]});
		job.pulse = pulse_ph > pulse_width_q;
		job.level = done ? '0 : level;
		job.done  = done;
	end

	`ASSERT_AT(a_level_range, level_q <= tosc_pkg::ENV_FULL, "envelope level above full scale")
	`ASSERT_NEVER(a_release_zero, stage_q == tosc_pkg::ST_RELEASE && level_q == '0,
		"release stage holding a zero level")
	`ASSERT_NEVER(a_done_level, stage_q == tosc_pkg::ST_DONE && level_q != '0,
		"done stage with a nonzero level")

endmodule

/* rtl/tosc_fifo.sv */
module tosc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  tosc_pkg::job_t wr_job,
	output logic           full,
	input  logic           rd,
	output tosc_pkg::job_t rd_job,
	output logic           empty
);

	tosc_pkg::job_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full   = count_q == 2'd2;
	assign empty  = count_q == 2'd0;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/tosc_back.sv */
`include "assert_macros.svh"

module tosc_back (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tosc_pkg::job_t                          job,
	input  logic                                    job_empty,
	output logic                                    job_pop,
	output logic signed [tosc_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                    envelope_done,
	output logic                                    empty,
	input  logic                                    pop
);

	tosc_pkg::back_state_t state_q;
	tosc_pkg::back_state_t state_d;

	tosc_pkg::job_t                          job_q;
	logic signed [tosc_pkg::MUL_A_BITS-1:0]  acc_q;
	logic signed [tosc_pkg::MUL_P_BITS-1:0]  p_q;
	logic [tosc_pkg::MUL_A_BITS-1:0]         mag_q;
	logic                                    neg_q;
	logic signed [tosc_pkg::SAMPLE_BITS-1:0] sample_q;
	logic                                    done_q;
	logic                                    out_valid_q;

	logic signed [tosc_pkg::MUL_A_BITS-1:0] mul_a;
	logic signed [tosc_pkg::MUL_B_BITS-1:0] mul_b;
	logic signed [tosc_pkg::MUL_P_BITS-1:0] prod;
	logic [tosc_pkg::MUL_P_BITS-1:0]        abs_p;
	logic [tosc_pkg::MUL_B_BITS-1:0]        mag_out;
	logic [tosc_pkg::MUL_B_BITS-1:0]        sat;
	logic [tosc_pkg::MUL_B_BITS-1:0]        res;
	logic                                   out_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tosc_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		out_wr  = 1'b0;
		case (state_q)
			tosc_pkg::B_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					state_d = tosc_pkg::B_MSINE;
				end
			end
			tosc_pkg::B_MSINE: state_d = tosc_pkg::B_MSAW;
			tosc_pkg::B_MSAW:  state_d = tosc_pkg::B_MIX;
			tosc_pkg::B_MIX:   state_d = tosc_pkg::B_MLVL;
			tosc_pkg::B_MLVL:  state_d = tosc_pkg::B_MAG;
			tosc_pkg::B_MAG:   state_d = tosc_pkg::B_MMAX;
			tosc_pkg::B_MMAX:  state_d = tosc_pkg::B_OUT;
			tosc_pkg::B_OUT: begin
				// hold here while the output register is still owed to the receiver
				if (!out_valid_q || pop) begin
					out_wr  = 1'b1;
					state_d = tosc_pkg::B_IDLE;
				end
			end
			default: state_d = tosc_pkg::B_IDLE;
		endcase
	end

	// operand select for the one shared multiplier
	always_comb begin
		case (state_q)
			tosc_pkg::B_MSINE: begin
				mul_a = tosc_pkg::MUL_A_BITS'(job_q.sine);
				mul_b = tosc_pkg::GAIN_SINE;
			end
			tosc_pkg::B_MSAW: begin
				mul_a = tosc_pkg::MUL_A_BITS'(job_q.saw);
				mul_b = tosc_pkg::GAIN_SAW;
			end
			tosc_pkg::B_MLVL: begin
				mul_a = acc_q;
				mul_b = $signed({1'b0, job_q.level});
			end
			default: begin
				mul_a = $signed(mag_q);
				mul_b = tosc_pkg::SAMPLE_MAX;
			end
		endcase
		prod = mul_a * mul_b;
	end

	always_comb begin
		abs_p   = p_q[tosc_pkg::MUL_P_BITS-1] ? 50'(-p_q) : 50'(p_q);
		mag_out = p_q[tosc_pkg::OUT_SHIFT +: tosc_pkg::MUL_B_BITS];
		if (neg_q) begin
			sat = (mag_out > 18'd32768) ? 18'd32768 : mag_out;
			res = -sat;
		end else begin
			sat = (mag_out > 18'd32767) ? 18'd32767 : mag_out;
			res = sat;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tosc_pkg::B_IDLE: begin
				if (job_pop) begin
					job_q <= job;
				end
			end
			tosc_pkg::B_MSINE: p_q <= prod;
			tosc_pkg::B_MSAW: begin
				acc_q <= p_q[tosc_pkg::MUL_A_BITS-1:0]
					+ (job_q.pulse ? tosc_pkg::PULSE_TERM : '0);
				p_q   <= prod;
			end
			tosc_pkg::B_MIX:  acc_q <= acc_q + p_q[tosc_pkg::MUL_A_BITS-1:0];
			tosc_pkg::B_MLVL: p_q <= prod;
			tosc_pkg::B_MAG: begin
				// product stays below 2^46, so the shifted magnitude fits 30 bits
				neg_q <= p_q[tosc_pkg::MUL_P_BITS-1];
				mag_q <= {2'b00, abs_p[tosc_pkg::LEVEL_SHIFT +: tosc_pkg::MUL_A_BITS-2]};
			end
			tosc_pkg::B_MMAX: p_q <= prod;
			default: ;
		endcase
		if (out_wr) begin
			sample_q <= $signed(res[tosc_pkg::SAMPLE_BITS-1:0]);
			done_q   <= job_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_wr) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sample        = sample_q;
	assign envelope_done = done_q;
	assign empty         = !out_valid_q;

	`ASSERT_AT(a_final_nonneg, state_q == tosc_pkg::B_OUT |-> !p_q[tosc_pkg::MUL_P_BITS-1],
		"scaled magnitude negative at output step")
	`ASSERT_AT(a_done_silent, state_q == tosc_pkg::B_OUT && job_q.done |-> p_q == '0,
		"done sample produced nonzero magnitude")
	`ASSERT_NEVER(a_pop_when_empty, job_pop && job_empty, "request taken from an empty queue")

endmodule

/* rtl/three_osc_synth_with_ar_envelope_top.sv */
// three-voice tone generator with attack-release envelope
//
// input queue side: each request pushed (push high, full low) is one sample
// tick; restart high clears the three phases and the envelope first.
// result queue side: while empty is low, sample and envelope_done show the
// oldest result; pop high takes it. results come out in request order.
// config: cfg_wen writes cfg_data to register cfg_index at the clock edge;
// write only while the block is idle.
// the front updates phases and envelope in the cycle a request is accepted
// and parks the voice values in a two-entry queue. the back runs them
// through one shared 32x18 multiplier in an eight-state sequence, one
// request at a time, while the front keeps taking requests until the
// queue is full. when pop stays low the output register holds the
// result, the back waits, the queue fills and full rises.
// reset (arst_n low) restores register defaults, zero phases and level,
// attack stage, and empties both queues.
module three_osc_synth_with_ar_envelope_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  logic                                    restart,
	output logic                                    empty,
	input  logic                                    pop,
	output logic signed [tosc_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                    envelope_done,
	input  logic                                    cfg_wen,
	input  logic [tosc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [tosc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	tosc_pkg::job_t front_job;
	tosc_pkg::job_t back_job;
	logic           accept;
	logic           job_empty;
	logic           job_pop;

	assign accept = push && !full;

	tosc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.restart   (restart),
		.job       (front_job)
	);

	tosc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wr_job (front_job),
		.full   (full),
		.rd     (job_pop),
		.rd_job (back_job),
		.empty  (job_empty)
	);

	tosc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (back_job),
		.job_empty     (job_empty),
		.job_pop       (job_pop),
		.sample        (sample),
		.envelope_done (envelope_done),
		.empty         (empty),
		.pop           (pop)
	);

endmodule
